// ===== rtl/mcr_pkg.sv =====
`default_nettype none
package mcr_pkg;

  localparam int unsigned PixelBits = 32;
  localparam logic [31:0] ColorMask = {32{1'b1}} >> (32 - PixelBits);

  localparam int unsigned CoordW  = 13;
  localparam int unsigned OffsetW = 12;
  localparam int unsigned PixelW  = 14;
  localparam int unsigned RadiusW = 11;
  localparam int unsigned DecW    = 16;
  localparam int unsigned DimW    = 13;

  localparam logic signed [DecW-1:0] DecInit  = 16'sd3;
  localparam logic signed [DecW-1:0] DecDiag  = 16'sd10;
  localparam logic signed [DecW-1:0] DecFlat  = 16'sd6;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_e;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_e;

  // One octant point to be mirrored into eight pixels.
  typedef struct packed {
    logic signed [CoordW-1:0]  cx;
    logic signed [CoordW-1:0]  cy;
    logic signed [OffsetW-1:0] xo;
    logic signed [OffsetW-1:0] yo;
    logic [31:0]               color;
    logic                      fin;
  } job_t;

  typedef struct packed {
    logic running;
    logic y_ge_x;
  } core_status_t;

  typedef struct packed {
    logic       job_valid;
    logic [2:0] idx;
  } emit_status_t;

endpackage
`default_nettype wire

// ===== rtl/mcr_core.sv =====
`default_nettype none
module mcr_core (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   accept_i,
  input  wire mcr_pkg::cmd_e                          cmd_i,
  input  wire logic signed [mcr_pkg::CoordW-1:0]      center_x_i,
  input  wire logic signed [mcr_pkg::CoordW-1:0]      center_y_i,
  input  wire logic [mcr_pkg::RadiusW-1:0]            radius_i,
  input  wire logic [31:0]                            draw_color_i,
  output mcr_pkg::job_t                               job_o,
  output logic                                        job_load_o,
  output mcr_pkg::core_status_t                       status_o
);

  logic                                   running_q, running_d;
  logic signed [mcr_pkg::CoordW-1:0]      cx_q, cx_d;
  logic signed [mcr_pkg::CoordW-1:0]      cy_q, cy_d;
  logic signed [mcr_pkg::OffsetW-1:0]     xo_q, xo_d;
  logic signed [mcr_pkg::OffsetW-1:0]     yo_q, yo_d;
  logic signed [mcr_pkg::DecW-1:0]        dec_q, dec_d;
  logic [31:0]                            color_q, color_d;

  logic signed [mcr_pkg::OffsetW-1:0]     x_nxt;
  logic signed [mcr_pkg::OffsetW-1:0]     y_nxt;
  logic signed [mcr_pkg::OffsetW:0]       diff;
  logic signed [mcr_pkg::DecW-1:0]        dec_step;
  logic                                   run_nxt;

  always_comb begin
    x_nxt = xo_q + 12'sd1;
    y_nxt = (dec_q > 16'sd0) ? yo_q - 12'sd1 : yo_q;
    diff  = {x_nxt[mcr_pkg::OffsetW-1], x_nxt} - {y_nxt[mcr_pkg::OffsetW-1], y_nxt};
    if (dec_q > 16'sd0) begin
      dec_step = dec_q + {{(mcr_pkg::DecW-mcr_pkg::OffsetW-3){diff[mcr_pkg::OffsetW]}},
                          diff, 2'b00} + mcr_pkg::DecDiag;
    end else begin
      dec_step = dec_q + {{(mcr_pkg::DecW-mcr_pkg::OffsetW-2){x_nxt[mcr_pkg::OffsetW-1]}},
                          x_nxt, 2'b00} + mcr_pkg::DecFlat;
    end
    run_nxt = (y_nxt >= x_nxt);
  end

  always_comb begin
    running_d  = running_q;
    cx_d       = cx_q;
    cy_d       = cy_q;
    xo_d       = xo_q;
    yo_d       = yo_q;
    dec_d      = dec_q;
    color_d    = color_q;
    job_load_o = 1'b0;
    if (accept_i) begin
      unique case (cmd_i)
        mcr_pkg::CMD_START: begin
          cx_d       = center_x_i;
          cy_d       = center_y_i;
          xo_d       = '0;
          yo_d       = signed'({1'b0, radius_i});
          dec_d      = mcr_pkg::DecInit - signed'({4'b0000, radius_i, 1'b0});
          color_d    = draw_color_i & mcr_pkg::ColorMask;
          running_d  = 1'b1;
          job_load_o = 1'b1;
        end
        mcr_pkg::CMD_STEP: begin
          if (running_q) begin
            xo_d       = x_nxt;
            yo_d       = y_nxt;
            dec_d      = dec_step;
            running_d  = run_nxt;
            job_load_o = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // The job carries the point as it stands after this item's update.
  always_comb begin
    job_o.cx    = cx_d;
    job_o.cy    = cy_d;
    job_o.xo    = xo_d;
    job_o.yo    = yo_d;
    job_o.color = color_d;
    job_o.fin   = ~running_d;
  end

  assign status_o.running = running_q;
  assign status_o.y_ge_x  = (yo_q >= xo_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      cx_q      <= '0;
      cy_q      <= '0;
      xo_q      <= '0;
      yo_q      <= '0;
      dec_q     <= '0;
      color_q   <= '0;
    end else begin
      running_q <= running_d;
      cx_q      <= cx_d;
      cy_q      <= cy_d;
      xo_q      <= xo_d;
      yo_q      <= yo_d;
      dec_q     <= dec_d;
      color_q   <= color_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/mcr_emit.sv =====
`default_nettype none
module mcr_emit (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              job_load_i,
  input  wire mcr_pkg::job_t                     job_i,
  input  wire logic [mcr_pkg::DimW-1:0]          width_i,
  input  wire logic [mcr_pkg::DimW-1:0]          height_i,
  output logic                                   job_free_o,
  input  wire logic                              out_ready_i,
  output logic                                   out_valid_o,
  output logic signed [mcr_pkg::PixelW-1:0]      pixel_x_o,
  output logic signed [mcr_pkg::PixelW-1:0]      pixel_y_o,
  output logic [31:0]                            pixel_value_o,
  output logic                                   inside_o,
  output logic                                   last_o,
  output logic                                   finished_o,
  output mcr_pkg::emit_status_t                  status_o
);

  mcr_pkg::job_t                          job_q;
  logic                                   job_vld_q;
  logic [2:0]                             idx_q;
  logic                                   load_out;
  logic                                   idx_last;

  logic signed [mcr_pkg::OffsetW-1:0]     ax;
  logic signed [mcr_pkg::OffsetW-1:0]     ay;
  logic signed [mcr_pkg::PixelW-1:0]      ax_w;
  logic signed [mcr_pkg::PixelW-1:0]      ay_w;
  logic signed [mcr_pkg::PixelW-1:0]      px_d;
  logic signed [mcr_pkg::PixelW-1:0]      py_d;
  logic                                   inside_d;

  assign load_out   = job_vld_q && (!out_valid_o || out_ready_i);
  assign idx_last   = (idx_q == 3'd7);
  assign job_free_o = !job_vld_q || (load_out && idx_last);

  // Index bit 2 swaps the axes, bit 1 mirrors the row, bit 0 mirrors the column.
  always_comb begin
    ax   = idx_q[2] ? job_q.yo : job_q.xo;
    ay   = idx_q[2] ? job_q.xo : job_q.yo;
    ax_w = {{(mcr_pkg::PixelW-mcr_pkg::OffsetW){ax[mcr_pkg::OffsetW-1]}}, ax};
    ay_w = {{(mcr_pkg::PixelW-mcr_pkg::OffsetW){ay[mcr_pkg::OffsetW-1]}}, ay};
    px_d = {job_q.cx[mcr_pkg::CoordW-1], job_q.cx} + (idx_q[0] ? -ax_w : ax_w);
    py_d = {job_q.cy[mcr_pkg::CoordW-1], job_q.cy} + (idx_q[1] ? -ay_w : ay_w);
    inside_d = !px_d[mcr_pkg::PixelW-1] && !py_d[mcr_pkg::PixelW-1] &&
               (px_d[mcr_pkg::DimW-1:0] < width_i) &&
               (py_d[mcr_pkg::DimW-1:0] < height_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_vld_q <= 1'b0;
      idx_q     <= '0;
    end else if (job_load_i) begin
      job_vld_q <= 1'b1;
      idx_q     <= '0;
    end else if (load_out) begin
      idx_q <= idx_q + 3'd1;
      if (idx_last) begin
        job_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_load_i) begin
      job_q <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (load_out) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      pixel_x_o     <= px_d;
      pixel_y_o     <= py_d;
      pixel_value_o <= job_q.color;
      inside_o      <= inside_d;
      last_o        <= idx_last;
      finished_o    <= idx_last && job_q.fin;
    end
  end

  assign status_o.job_valid = job_vld_q;
  assign status_o.idx       = idx_q;

endmodule
`default_nettype wire

// ===== rtl/midpoint_circle_rasterizer_unit.sv =====
`default_nettype none
// Midpoint circle outline generator. A start transfer (tuser 0) loads center, radius
// and color and yields the eight mirrored pixels of the top point; each step transfer
// (tuser 1) advances one octant point and yields eight more, the final one flagged as
// finished. A step while no circle is in progress yields nothing. Every pixel-producing
// item yields one pixel a cycle through the single output register while m_axis_tready
// stays high, and the next item is taken while the eighth pixel waits. The first pixel
// is offered once its input has passed the job register and then the output register.
// Surface width and height registers (index 0 and 1, reset 640 and 480) set the inside
// flag; write them only while no pixels are pending.
module midpoint_circle_rasterizer_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic                        cfg_addr_i,
  input  wire logic [mcr_pkg::DimW-1:0]    cfg_wdata_i,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  // center_x[12:0], center_y[25:13], radius[36:26], draw_color[68:37], zero[71:69]
  input  wire logic [71:0]                 s_axis_tdata,
  // cmd[0]
  input  wire logic [0:0]                  s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  // pixel_x[13:0], pixel_y[27:14], pixel_value[59:28], zero[63:60]
  output logic [63:0]                      m_axis_tdata,
  // inside_res[0], finished[1]
  output logic [1:0]                       m_axis_tuser,
  output logic                             m_axis_tlast
);

  logic [mcr_pkg::DimW-1:0]                width_q;
  logic [mcr_pkg::DimW-1:0]                height_q;

  logic                                    accept;
  mcr_pkg::job_t                           job;
  logic                                    job_load;
  mcr_pkg::core_status_t                   core_st;
  mcr_pkg::emit_status_t                   emit_st;
  logic signed [mcr_pkg::PixelW-1:0]       pixel_x;
  logic signed [mcr_pkg::PixelW-1:0]       pixel_y;
  logic [31:0]                             pixel_value;
  logic                                    inside_res;
  logic                                    finished;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 13'd640;
      height_q <= 13'd480;
    end else if (cfg_we_i) begin
      unique case (mcr_pkg::reg_idx_e'(cfg_addr_i))
        mcr_pkg::REG_WIDTH:  width_q  <= cfg_wdata_i;
        mcr_pkg::REG_HEIGHT: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign accept = s_axis_tvalid && s_axis_tready;

  mcr_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .cmd_i        (mcr_pkg::cmd_e'(s_axis_tuser[0])),
    .center_x_i   (s_axis_tdata[12:0]),
    .center_y_i   (s_axis_tdata[25:13]),
    .radius_i     (s_axis_tdata[36:26]),
    .draw_color_i (s_axis_tdata[68:37]),
    .job_o        (job),
    .job_load_o   (job_load),
    .status_o     (core_st)
  );

  mcr_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_load_i    (job_load),
    .job_i         (job),
    .width_i       (width_q),
    .height_i      (height_q),
    .job_free_o    (s_axis_tready),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .pixel_x_o     (pixel_x),
    .pixel_y_o     (pixel_y),
    .pixel_value_o (pixel_value),
    .inside_o      (inside_res),
    .last_o        (m_axis_tlast),
    .finished_o    (finished),
    .status_o      (emit_st)
  );

  assign m_axis_tdata = {4'b0000, pixel_value, pixel_y, pixel_x};
  assign m_axis_tuser = {finished, inside_res};

`ifndef SYNTHESIS
  // The finished flag only ever rides on the eighth pixel of an item.
  a_fin_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
    else $error("finished pixel is not the last of its item");

  // A circle in progress never has its x offset past its y offset.
  a_octant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_st.running |-> core_st.y_ge_x)
    else $error("running circle has crossed the diagonal");

  // With no job held the input side must be open.
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !emit_st.job_valid |-> s_axis_tready)
    else $error("input stalled with no pending job");

  // Once the last pixel leaves and no job is held, the output goes quiet.
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tlast && !emit_st.job_valid
    |=> !m_axis_tvalid)
    else $error("pixel produced without a job");
`endif

endmodule
`default_nettype wire
